[hw/rtl/ast_pkg.sv]
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the audio silence trimmer.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int THRESH_W   = 15;
  localparam int CHCNT_W    = 4;
  localparam int NUM_FIELDS = 8;   // sample fields carried by every item

  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd328;
  localparam logic [CHCNT_W-1:0]  CHCNT_RESET  = 4'd2;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
    logic signed [SAMPLE_W-1:0] sample_4;
    logic signed [SAMPLE_W-1:0] sample_5;
    logic signed [SAMPLE_W-1:0] sample_6;
    logic signed [SAMPLE_W-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_0;
    logic signed [SAMPLE_W-1:0] out_1;
    logic signed [SAMPLE_W-1:0] out_2;
    logic signed [SAMPLE_W-1:0] out_3;
    logic signed [SAMPLE_W-1:0] out_4;
    logic signed [SAMPLE_W-1:0] out_5;
    logic signed [SAMPLE_W-1:0] out_6;
    logic signed [SAMPLE_W-1:0] out_7;
    logic                       last_of_run;
  } out_item_t;

  // Input side status handed from the datapath to the hold controller.
  typedef struct packed {
    logic valid;
    logic func;
    logic loud;
  } frame_ctl_t;

  // Output side status of the hold controller.
  typedef struct packed {
    logic valid;
    logic last;
  } out_ctl_t;

endpackage

[hw/rtl/ast_if.sv]
// ----------------------------------------------------------------------------
// ast_if
// Valid/ready stream interfaces for input frames and emitted frames.
// ----------------------------------------------------------------------------
interface ast_in_if
  import ast_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ast_out_if
  import ast_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/audio_silence_trimmer_core.sv]
// ----------------------------------------------------------------------------
// audio_silence_trimmer_core
// Silence removal gate: drops leading silence, holds trailing silent frames.
// ----------------------------------------------------------------------------
//
//   port        dir   kind           payload
//   ---------   ---   ------------   ---------------------------------------
//   audio_in    in    valid/ready    func, sample_0..sample_7
//   audio_out   out   valid/ready    out_0..out_7, last_of_run
//   cfg_*       in    write only     threshold (index 0), channel_count (1)
//
// Pacing: a flush, or a silent frame on a FIFO not full, is taken with no
// stall. A loud frame with N frames held gives N+1 items, one per cycle
// while audio_out is ready, and input waits until the loud frame leaves the
// read stage; the single read port of the hold memory sets this pace.
// On a full FIFO a silent frame stalls input likewise, for the evicted frame.
// Reset: synchronous, clears the FIFO pointers, re-arms leading-silence
// skipping and loads the register defaults; the hold memory is not cleared.
// Stalls: a result waits in the output register while the next input is
// accepted; backpressure on audio_out stops the drain without loss.
//
module audio_silence_trimmer_core
  import ast_pkg::*;
#(
  parameter int HOLD_FRAMES  = 63,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  ast_in_if.sink                audio_in,
  ast_out_if.source             audio_out,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W = MAX_CHANNELS * SAMPLE_W;

  // configuration registers
  logic [THRESH_W-1:0] threshold;
  logic [CHCNT_W-1:0]  channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESH_RESET;
      channel_count <= CHCNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_THRESHOLD:     threshold     <= cfg_data[THRESH_W-1:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CHCNT_W-1:0];
        default:           threshold     <= threshold;
      endcase
    end
  end

  // unpack the fixed set of sample fields for lane indexing
  logic [NUM_FIELDS-1:0][SAMPLE_W-1:0] in_samples;

  assign in_samples[0] = audio_in.data.sample_0;
  assign in_samples[1] = audio_in.data.sample_1;
  assign in_samples[2] = audio_in.data.sample_2;
  assign in_samples[3] = audio_in.data.sample_3;
  assign in_samples[4] = audio_in.data.sample_4;
  assign in_samples[5] = audio_in.data.sample_5;
  assign in_samples[6] = audio_in.data.sample_6;
  assign in_samples[7] = audio_in.data.sample_7;

  // Lanes: channel 0 is always active (a count of zero means one channel),
  // and a count above MAX_CHANNELS simply enables every lane.
  logic [MAX_CHANNELS-1:0]               lane_loud;
  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] lane_kept;

  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
    ast_lane u_lane (
      .active    ((k == 0) || (CHCNT_W'(k) < channel_count)),
      .sample    (in_samples[k]),
      .threshold (threshold),
      .kept      (lane_kept[k]),
      .loud      (lane_loud[k])
    );
  end

  logic             frame_loud;
  logic [ROW_W-1:0] frame_word;

  ast_merge #(
    .LANES (MAX_CHANNELS)
  ) u_merge (
    .lane_loud (lane_loud),
    .lane_kept (lane_kept),
    .loud      (frame_loud),
    .frame     (frame_word)
  );

  frame_ctl_t       in_ctl;
  out_ctl_t         out_ctl;
  logic [ROW_W-1:0] out_word;

  assign in_ctl.valid = audio_in.valid;
  assign in_ctl.func  = audio_in.data.func;
  assign in_ctl.loud  = frame_loud;

  ast_hold_ctrl #(
    .HOLD_FRAMES (HOLD_FRAMES),
    .ROW_W       (ROW_W)
  ) u_hold (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (in_ctl),
    .in_ready  (audio_in.ready),
    .in_frame  (frame_word),
    .out_ctl   (out_ctl),
    .out_ready (audio_out.ready),
    .out_frame (out_word)
  );

  // channels beyond MAX_CHANNELS are never stored and come out as zero
  logic [NUM_FIELDS-1:0][SAMPLE_W-1:0] out_samples;

  always_comb begin
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (k < MAX_CHANNELS) begin
        out_samples[k] = out_word[k*SAMPLE_W +: SAMPLE_W];
      end else begin
        out_samples[k] = '0;
      end
    end
  end

  assign audio_out.valid            = out_ctl.valid;
  assign audio_out.data.out_0       = out_samples[0];
  assign audio_out.data.out_1       = out_samples[1];
  assign audio_out.data.out_2       = out_samples[2];
  assign audio_out.data.out_3       = out_samples[3];
  assign audio_out.data.out_4       = out_samples[4];
  assign audio_out.data.out_5       = out_samples[5];
  assign audio_out.data.out_6       = out_samples[6];
  assign audio_out.data.out_7       = out_samples[7];
  assign audio_out.data.last_of_run = out_ctl.last;

endmodule

[hw/rtl/ast_lane.sv]
// ----------------------------------------------------------------------------
// ast_lane
// One channel lane: masks an inactive channel, checks magnitude vs threshold.
// ----------------------------------------------------------------------------
module ast_lane
  import ast_pkg::*;
(
  input  logic                active,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [THRESH_W-1:0] threshold,
  output logic [SAMPLE_W-1:0] kept,
  output logic                loud
);

  logic [SAMPLE_W:0] mag;

  // -32768 yields 32768, so the magnitude needs one extra bit
  always_comb begin
    if (sample[SAMPLE_W-1]) begin
      mag = {1'b0, ~sample} + (SAMPLE_W+1)'(1);
    end else begin
      mag = {1'b0, sample};
    end
  end

  assign loud = active && (mag > {2'b00, threshold});
  assign kept = active ? sample : '0;

endmodule

[hw/rtl/ast_merge.sv]
// ----------------------------------------------------------------------------
// ast_merge
// Combines lane results: frame loudness and the packed frame word.
// ----------------------------------------------------------------------------
module ast_merge
  import ast_pkg::*;
#(
  parameter int LANES = 8
) (
  input  logic [LANES-1:0]               lane_loud,
  input  logic [LANES-1:0][SAMPLE_W-1:0] lane_kept,
  output logic                           loud,
  output logic [LANES*SAMPLE_W-1:0]      frame
);

  assign loud = |lane_loud;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      frame[k*SAMPLE_W +: SAMPLE_W] = lane_kept[k];
    end
  end

endmodule

[hw/rtl/ast_hold_ctrl.sv]
// ----------------------------------------------------------------------------
// ast_hold_ctrl
// Hold FIFO of silent frames, drain sequencer and output register.
// ----------------------------------------------------------------------------
module ast_hold_ctrl
  import ast_pkg::*;
#(
  parameter int HOLD_FRAMES = 63,
  parameter int ROW_W       = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  frame_ctl_t       in_ctl,
  output logic             in_ready,
  input  logic [ROW_W-1:0] in_frame,
  output out_ctl_t         out_ctl,
  input  logic             out_ready,
  output logic [ROW_W-1:0] out_frame
);

  localparam int HW = (HOLD_FRAMES > 1) ? $clog2(HOLD_FRAMES) : 1;
  localparam int CW = $clog2(HOLD_FRAMES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_EVICT = 2'd2;

  logic [1:0]  state;
  logic [HW-1:0] hold_head;
  logic [CW-1:0] hold_count;
  logic          leading_silence;

  logic [ROW_W-1:0] hold_store [HOLD_FRAMES];
  logic [ROW_W-1:0] mem_q;
  logic [ROW_W-1:0] cur_frame;

  // read stage: one frame on its way to the output register
  logic rd_valid;
  logic rd_from_mem;
  logic rd_last;

  // output register flags
  logic out_valid;
  logic out_last;

  logic          accept;
  logic          rd_move;
  logic          rd_issue;
  logic          issue_ok;
  logic          mem_rd;
  logic          mem_we;
  logic [HW-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [HW-1:0] head_inc;
  logic [CW:0]   tail_sum;
  logic [HW-1:0] tail;
  logic          full;

  assign in_ready = (state == ST_IDLE) && !rd_valid;
  assign accept   = in_ctl.valid && in_ready;
  assign rd_move  = rd_valid && (!out_valid || out_ready);
  assign issue_ok = !rd_valid || rd_move;
  assign rd_issue = ((state == ST_DRAIN) || (state == ST_EVICT)) && issue_ok;
  assign full     = (hold_count == CW'(HOLD_FRAMES));

  assign out_ctl = '{valid: out_valid, last: out_last};

  assign head_inc = (hold_head == HW'(HOLD_FRAMES - 1)) ? '0 : hold_head + HW'(1);

  always_comb begin
    tail_sum = (CW+1)'(hold_head) + (CW+1)'(hold_count);
    if (tail_sum >= (CW+1)'(HOLD_FRAMES)) begin
      tail_sum = tail_sum - (CW+1)'(HOLD_FRAMES);
    end
    tail = tail_sum[HW-1:0];
  end

  // memory port controls
  always_comb begin
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = tail;
    mem_wdata = in_frame;
    unique case (state)
      ST_IDLE: begin
        mem_we = accept && (in_ctl.func == FUNC_FRAME) && !in_ctl.loud
                 && !leading_silence && !full;
      end
      ST_DRAIN: begin
        mem_rd = issue_ok && (hold_count != '0);
      end
      ST_EVICT: begin
        // read-before-write on the same row: oldest out, newest in
        mem_rd    = issue_ok;
        mem_we    = issue_ok;
        mem_waddr = hold_head;
        mem_wdata = cur_frame;
      end
      default: begin
        mem_rd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      mem_q <= hold_store[hold_head];
    end
    if (mem_we) begin
      hold_store[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_frame <= in_frame;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      hold_head       <= '0;
      hold_count      <= '0;
      leading_silence <= 1'b1;
      rd_valid        <= 1'b0;
      rd_from_mem     <= 1'b0;
      rd_last         <= 1'b0;
    end else begin
      if (rd_issue) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_ctl.func == FUNC_FLUSH) begin
              hold_head       <= '0;
              hold_count      <= '0;
              leading_silence <= 1'b1;
            end else if (in_ctl.loud) begin
              leading_silence <= 1'b0;
              state           <= ST_DRAIN;
            end else if (!leading_silence) begin
              if (full) begin
                state <= ST_EVICT;
              end else begin
                hold_count <= hold_count + CW'(1);
              end
            end
          end
        end
        ST_DRAIN: begin
          if (issue_ok) begin
            if (hold_count != '0) begin
              rd_from_mem <= 1'b1;
              rd_last     <= 1'b0;
              hold_head   <= head_inc;
              hold_count  <= hold_count - CW'(1);
            end else begin
              rd_from_mem <= 1'b0;
              rd_last     <= 1'b1;
              hold_head   <= '0;
              state       <= ST_IDLE;
            end
          end
        end
        ST_EVICT: begin
          if (issue_ok) begin
            rd_from_mem <= 1'b1;
            rd_last     <= 1'b1;
            hold_head   <= head_inc;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      out_frame <= rd_from_mem ? mem_q : cur_frame;
      out_last  <= rd_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hold_count <= CW'(HOLD_FRAMES))
    else $error("hold count above FIFO depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    hold_head <= HW'(HOLD_FRAMES - 1))
    else $error("hold head out of range");

  a_lead_empty: assert property (@(posedge clk) disable iff (rst)
    leading_silence |-> (hold_count == '0))
    else $error("frames held during leading silence");

  a_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ctl.func == FUNC_FLUSH) |=>
      (hold_count == '0 && hold_head == '0 && leading_silence))
    else $error("flush did not re-arm");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && issue_ok && hold_count == '0) |=>
      (rd_valid && rd_last && !rd_from_mem && state == ST_IDLE))
    else $error("current frame not issued after drain");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks audio_silence_trimmer_core against a frame-level predictor: leading
// silence drop, hold FIFO of silent frames, drain on loud frames, eviction on
// a full FIFO and flush. Directed frames first, then random frame sequences
// under several threshold and channel settings, with random idling on both
// streams.
// ----------------------------------------------------------------------------
module testbench;
  import ast_pkg::*;

  localparam int HOLD      = 63;
  localparam int MAX_CH    = 8;
  localparam int SETTLE    = HOLD + 8;   // drain of a full FIFO plus margin
  localparam int LIMIT     = 400000;
  localparam int PRINT_CAP = 40;
  localparam int IN_W      = $bits(in_item_t);

  // Predicts emitted frames from accepted input items and checks the
  // frames that come out of the block, in order.
  class trim_scoreboard;
    localparam int HOLD_DEPTH = 63;

    logic [THRESH_W-1:0] threshold;
    logic [CHCNT_W-1:0]  chan_reg;
    bit                  in_leading;
    out_item_t           held[$];
    out_item_t           expected[$];
    int                  errors;

    function new();
      threshold  = THRESH_RESET;
      chan_reg   = CHCNT_RESET;
      in_leading = 1'b1;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_THRESHOLD) begin
        threshold = val[THRESH_W-1:0];
      end else begin
        chan_reg = val[CHCNT_W-1:0];
      end
    endfunction

    // zero means one channel, anything past the max saturates
    function int active_chans();
      if (chan_reg == 0) return 1;
      if (chan_reg > MAX_CH) return MAX_CH;
      return int'(chan_reg);
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void note_input(in_item_t it);
      out_item_t        fr;
      out_item_t        e;
      logic [15:0]      s;
      logic [16:0]      mag;
      bit               loud;
      int               n;
      n    = active_chans();
      loud = 1'b0;
      fr   = '0;
      if (it.func == FUNC_FLUSH) begin
        held.delete();
        in_leading = 1'b1;
        return;
      end
      for (int j = 0; j < n; j++) begin
        s = it[16*(7-j) +: 16];
        fr[1+16*(7-j) +: 16] = s;
        mag = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
        if (mag > {2'b00, threshold}) loud = 1'b1;
      end
      if (loud) begin
        in_leading = 1'b0;
        while (held.size() > 0) begin
          e = held.pop_front();
          e.last_of_run = 1'b0;
          expected.push_back(e);
        end
        fr.last_of_run = 1'b1;
        expected.push_back(fr);
      end else if (!in_leading) begin
        // full FIFO: oldest frame goes out as the only result
        if (held.size() >= HOLD_DEPTH) begin
          e = held.pop_front();
          e.last_of_run = 1'b1;
          expected.push_back(e);
        end
        held.push_back(fr);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        report($sformatf("frame %h with nothing expected", got));
        return;
      end
      want = expected.pop_front();
      for (int j = 0; j < MAX_CH; j++) begin
        if (got[1+16*(7-j) +: 16] !== want[1+16*(7-j) +: 16])
          report($sformatf("out_%0d got %h want %h", j,
                           got[1+16*(7-j) +: 16], want[1+16*(7-j) +: 16]));
      end
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run got %b want %b",
                         got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    no_idle;
  int                    cycles;
  trim_scoreboard        sb;

  ast_in_if  audio_in ();
  ast_out_if audio_out ();

  audio_silence_trimmer_core #(
    .HOLD_FRAMES (HOLD),
    .MAX_CHANNELS(MAX_CH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .audio_in (audio_in.sink),
    .audio_out(audio_out.source),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Idle at a chance of 15 in a hundred, never while no_idle is set.
  function bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 15);
  endfunction

  // Present one item and hold it until the block takes it. Valid drops only
  // when an idle cycle follows, so it is never lowered and raised in one step.
  task automatic send_item(in_item_t it);
    while (idle_now()) begin
      audio_in.valid <= 1'b0;
      @(posedge clk);
    end
    audio_in.valid <= 1'b1;
    audio_in.data  <= it;
    @(posedge clk);
    while (!audio_in.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering input, wait for every predicted frame, then give the block
  // time to settle (a silent frame leaves nothing to wait for).
  task automatic wait_idle();
    audio_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Two-channel frame for the directed part; upper channels share one value.
  function in_item_t two_ch(logic [15:0] a, logic [15:0] b, logic [15:0] rest);
    return {FUNC_FRAME, a, b, rest, rest, rest, rest, rest, rest};
  endfunction

  function in_item_t flush_item();
    in_item_t it;
    it      = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.func = FUNC_FLUSH;
    return it;
  endfunction

  // Random frame for the current settings. Inactive channels carry noise,
  // active ones stay at or under threshold unless one is made loud.
  function in_item_t gen_frame(bit want_loud);
    in_item_t    it;
    logic [16:0] m;
    int          n;
    int          k;
    int          thr;
    n   = sb.active_chans();
    thr = int'(sb.threshold);
    it  = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.func = FUNC_FRAME;
    for (int j = 0; j < n; j++) begin
      m = ($urandom_range(0, 7) == 0) ? 17'(thr) : 17'($urandom_range(0, thr));
      it[16*(7-j) +: 16] = $urandom_range(0, 1) ? 16'(-m) : m[15:0];
    end
    if (want_loud) begin
      k = $urandom_range(0, n - 1);
      m = 17'($urandom_range(thr + 1, 32768));
      if (m == 17'h08000) begin
        it[16*(7-k) +: 16] = 16'h8000;
      end else begin
        it[16*(7-k) +: 16] = $urandom_range(0, 1) ? 16'(-m) : m[15:0];
      end
    end
    return it;
  endfunction

  // Mostly well-formed runs: loud frame, short silent stretches and loud
  // frames, sometimes a flush. Some raw noise and stray flushes mixed in.
  task automatic run_random(int items);
    int count;
    int r;
    int bursts;
    int len;
    int lead;
    count = 0;
    while (count < items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item({FUNC_FRAME, $urandom, $urandom, $urandom, $urandom});
        count++;
      end else if (r < 14) begin
        send_item(flush_item());
        count++;
      end else begin
        lead = $urandom_range(0, 2);
        repeat (lead) send_item(gen_frame(1'b0));
        send_item(gen_frame(1'b1));
        count += lead + 1;
        bursts = $urandom_range(1, 3);
        repeat (bursts) begin
          len = $urandom_range(0, 6);
          repeat (len) send_item(gen_frame(1'b0));
          send_item(gen_frame(1'b1));
          count += len + 1;
        end
        if ($urandom_range(0, 1)) begin
          send_item(flush_item());
          count++;
        end
      end
    end
  endtask

  task automatic set_phase(int thr, int chans);
    wait_idle();
    write_cfg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_cfg(CFG_CHANNEL_COUNT, CFG_DATA_W'(chans));
  endtask

  // Output side: random stalls, checking every accepted frame.
  initial begin
    audio_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && audio_out.valid && audio_out.ready) sb.check_result(audio_out.data);
      audio_out.ready <= !idle_now();
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    sb              = new();
    no_idle         = 1'b0;
    rst            <= 1'b1;
    cfg_write      <= 1'b0;
    cfg_index      <= CFG_THRESHOLD;
    cfg_data       <= '0;
    audio_in.valid <= 1'b0;
    audio_in.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset settings: threshold 328, two channels.
    send_item(two_ch(16'd100, -16'sd200, 16'h7FFF));  // leading silence, dropped
    send_item(two_ch(16'd0, 16'd0, 16'h8000));        // loud only on inactive lanes
    send_item(two_ch(16'h8000, 16'd5, 16'h1234));     // full-scale negative is loud
    send_item(two_ch(16'd328, -16'sd328, 16'hFFFF));  // exactly at threshold: held
    send_item(two_ch(-16'sd1, 16'd0, 16'h7FFF));      // held
    send_item(two_ch(16'd0, 16'd329, 16'h0000));      // drains two, then itself
    send_item(two_ch(16'h7FFF, -16'sd32767, 16'hAAAA));
    send_item(two_ch(16'd0, 16'd0, 16'h5555));        // held
    send_item(flush_item());                          // held frame discarded
    send_item(two_ch(16'd12, -16'sd7, 16'hFFFF));     // leading again, dropped
    send_item(two_ch(16'd0, -16'sd329, 16'h8000));
    send_item(two_ch(16'hFEB8, 16'd1, 16'h7FFF));     // -328: held
    send_item(two_ch(16'd327, 16'd328, 16'h0001));    // held
    send_item(two_ch(16'd0, 16'h7FFF, 16'hFFFE));
    send_item(flush_item());
    send_item(flush_item());
    send_item({FUNC_FLUSH, {8{16'hFFFF}}});

    // Zero threshold, one channel, no idling on either side.
    no_idle = 1'b1;
    set_phase(0, 1);
    run_random(20);
    no_idle = 1'b0;

    // Top threshold, all channels: only -32768 is loud. A long silent run
    // fills the FIFO, evicts the oldest frames, then a loud frame drains it.
    set_phase(32767, 8);
    send_item(gen_frame(1'b1));
    repeat (HOLD + 2) send_item(gen_frame(1'b0));
    send_item(gen_frame(1'b1));
    run_random(10);

    // Channel count zero acts as one; above the max saturates.
    set_phase($urandom_range(0, 32767), 0);
    run_random(10);
    set_phase($urandom_range(0, 2000), 15);
    run_random(10);
    set_phase($urandom_range(0, 32767), $urandom_range(0, 15));
    run_random(10);
    set_phase($urandom_range(0, 4000), $urandom_range(1, 8));
    run_random(10);

    wait_idle();

    if (sb.pending() != 0) sb.report($sformatf("%0d frames never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ast_pkg.sv
hw/rtl/ast_if.sv
hw/rtl/ast_lane.sv
hw/rtl/ast_merge.sv
hw/rtl/ast_hold_ctrl.sv
hw/rtl/audio_silence_trimmer_core.sv
tb/testbench.sv
